// File: rtl/stem_pkg.sv
package stem_pkg;

    // Most expiries reported for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;
    localparam int ENTRY_W     = 4;
    localparam int FIELD_W     = 32;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FETCH,
        ST_APPLY,
        ST_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_arm;
        logic accept_tick;
        logic scan_clear;
        logic scan_rd;
        logic best_rd;
        logic apply;
        logic push_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic running;
        logic scan_last;
        logic found;
        logic pend_valid;
        logic out_free;
        logic res_full;
    } sts_t;

endpackage

// File: rtl/stem_ctrl.sv
module stem_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              mode,
    output logic              in_stall,
    input  stem_pkg::sts_t    sts,
    output stem_pkg::cmd_t    cmd
);

    stem_pkg::state_t state_reg;
    stem_pkg::state_t state_next;
    logic             take;

    assign take = in_valid && (state_reg == stem_pkg::ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stem_pkg::ST_IDLE:
            begin
                if (take && !mode && sts.running)
                begin
                    state_next = stem_pkg::ST_SCAN;
                end
            end
            stem_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = stem_pkg::ST_DRAIN;
                end
            end
            stem_pkg::ST_DRAIN:
            begin
                state_next = stem_pkg::ST_DECIDE;
            end
            stem_pkg::ST_DECIDE:
            begin
                state_next = sts.found ? stem_pkg::ST_FETCH : stem_pkg::ST_FLUSH;
            end
            stem_pkg::ST_FETCH:
            begin
                state_next = stem_pkg::ST_APPLY;
            end
            stem_pkg::ST_APPLY:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = sts.res_full ? stem_pkg::ST_FLUSH : stem_pkg::ST_SCAN;
                end
            end
            stem_pkg::ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = stem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stem_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != stem_pkg::ST_IDLE);
        case (state_reg)
            stem_pkg::ST_IDLE:
            begin
                cmd.accept_arm  = take && mode;
                cmd.accept_tick = take && !mode && sts.running;
                cmd.scan_clear  = take && !mode && sts.running;
            end
            stem_pkg::ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            stem_pkg::ST_FETCH:
            begin
                cmd.best_rd = 1'b1;
            end
            stem_pkg::ST_APPLY:
            begin
                cmd.apply      = !sts.pend_valid || sts.out_free;
                cmd.scan_clear = !sts.pend_valid || sts.out_free;
            end
            stem_pkg::ST_FLUSH:
            begin
                cmd.push_last = sts.pend_valid && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/stem_dp.sv
module stem_dp
#(
    parameter int TIMERS    = 16,
    parameter int TICK_BITS = 32,
    parameter int IW        = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  stem_pkg::cmd_t                  cmd,
    output stem_pkg::sts_t                  sts,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    input  logic [stem_pkg::ENTRY_W-1:0]    entry,
    input  logic [stem_pkg::FIELD_W-1:0]    delay,
    input  logic [stem_pkg::FIELD_W-1:0]    reload,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [stem_pkg::ENTRY_W-1:0]    expired_entry,
    output logic                            rearmed,
    output logic                            last
);

    logic                 running_reg;
    logic [TICK_BITS-1:0] count_reg;
    logic [TICK_BITS-1:0] count_next;
    logic [TIMERS-1:0]    armed_reg;
    logic [TIMERS-1:0]    armed_next;
    logic [TIMERS-1:0]    ovf_reg;
    logic [TIMERS-1:0]    ovf_next;

    logic [TICK_BITS-1:0] arr_mem [0:TIMERS-1];
    logic [TICK_BITS-1:0] rld_mem [0:TIMERS-1];
    logic [TICK_BITS-1:0] arr_q_reg;
    logic [TICK_BITS-1:0] rld_q_reg;

    logic [IW-1:0]        scan_idx_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 pv_reg;
    logic                 found_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [TICK_BITS-1:0] best_arr_reg;
    logic [stem_pkg::RES_CNT_W-1:0] res_cnt_reg;

    logic                 pend_valid_reg;
    logic [stem_pkg::ENTRY_W-1:0] pend_idx_reg;
    logic                 pend_again_reg;
    logic                 out_valid_reg;
    logic [stem_pkg::ENTRY_W-1:0] out_idx_reg;
    logic                 out_again_reg;
    logic                 out_last_reg;

    logic [63:0]          dly_ext;
    logic [63:0]          rld_ext;
    logic [TICK_BITS-1:0] dly_w;
    logic [TICK_BITS-1:0] rld_w;
    logic [IW+3:0]        ent_ext;
    logic [IW-1:0]        ent_idx;
    logic                 ent_ok;
    logic                 arm_write;
    logic [TICK_BITS-1:0] arm_when;
    logic                 arm_ovf;
    logic [TICK_BITS-1:0] ap_when;
    logic                 ap_ovf;
    logic                 again;
    logic [IW+3:0]        best_ext;
    logic                 wrap;
    logic                 elig;
    logic                 out_free;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;

    // Input fields cut to the tick width and the table index.
    assign dly_ext   = 64'(delay);
    assign rld_ext   = 64'(reload);
    assign dly_w     = dly_ext[TICK_BITS-1:0];
    assign rld_w     = rld_ext[TICK_BITS-1:0];
    assign ent_ext   = (IW+4)'(entry);
    assign ent_idx   = ent_ext[IW-1:0];
    assign ent_ok    = (32'(entry) < 32'(TIMERS));
    assign arm_write = cmd.accept_arm && ent_ok && (dly_w != '0);
    assign arm_when  = count_reg + dly_w;
    assign arm_ovf   = (arm_when < count_reg);

    // Rearm arithmetic for the chosen entry.
    assign again    = (rld_q_reg != '0);
    assign ap_when  = count_reg + rld_q_reg;
    assign ap_ovf   = (ap_when < count_reg);
    assign best_ext = (IW+4)'(best_idx_reg);

    assign wrap     = &count_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_en    = cmd.scan_rd || cmd.best_rd;
    assign rd_addr  = cmd.best_rd ? best_idx_reg : scan_idx_reg;
    assign elig     = armed_reg[rd_idx_reg] && !ovf_reg[rd_idx_reg]
                      && (arr_q_reg <= count_reg);

    // Status to the controller.
    always_comb
    begin
        sts.running    = running_reg;
        sts.scan_last  = (scan_idx_reg == IW'(TIMERS - 1));
        sts.found      = found_reg;
        sts.pend_valid = pend_valid_reg;
        sts.out_free   = out_free;
        sts.res_full   = (res_cnt_reg == stem_pkg::RES_CNT_W'(stem_pkg::MAX_RESULTS - 1));
    end

    // Tick count and entry flags.
    always_comb
    begin
        count_next = count_reg;
        armed_next = armed_reg;
        ovf_next   = ovf_reg;
        if (cmd.accept_tick)
        begin
            count_next = count_reg + 1'b1;
            if (wrap)
            begin
                for (int i = 0; i < TIMERS; i++)
                begin
                    if (armed_reg[i])
                    begin
                        ovf_next[i] = ~ovf_reg[i];
                    end
                end
            end
        end
        if (arm_write)
        begin
            armed_next[ent_idx] = 1'b1;
            ovf_next[ent_idx]   = arm_ovf;
        end
        if (cmd.apply)
        begin
            if (again)
            begin
                ovf_next[best_idx_reg] = ap_ovf;
            end
            else
            begin
                armed_next[best_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            count_reg   <= '0;
            armed_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                running_reg <= cfg_data;
            end
            count_reg <= count_next;
            armed_reg <= armed_next;
        end
    end

    // Overflow flags are only read while armed, so they need no reset.
    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
    end

    assign cfg_ready = 1'b1;

    // Arrival and reload memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (arm_write)
        begin
            arr_mem[ent_idx] <= arm_when;
            rld_mem[ent_idx] <= rld_w;
        end
        else if (cmd.apply && again)
        begin
            arr_mem[best_idx_reg] <= ap_when;
        end
        if (rd_en)
        begin
            arr_q_reg <= arr_mem[rd_addr];
            rld_q_reg <= rld_mem[rd_addr];
        end
    end

    // Scan of the table for the earliest due entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_idx_reg   <= '0;
            pv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            pv_reg     <= cmd.scan_rd;
            rd_idx_reg <= scan_idx_reg;
            if (cmd.scan_clear)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (pv_reg && elig && (!found_reg || (arr_q_reg < best_arr_reg)))
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.accept_tick)
            begin
                res_cnt_reg <= '0;
            end
            else if (cmd.apply)
            begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
            end
        end
    end

    // The best candidate itself is payload.
    always_ff @(posedge clk)
    begin
        if (pv_reg && elig && (!found_reg || (arr_q_reg < best_arr_reg)))
        begin
            best_idx_reg <= rd_idx_reg;
            best_arr_reg <= arr_q_reg;
        end
    end

    // A result is held back until the next scan shows whether it is the last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.push_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.apply && pend_valid_reg) || cmd.push_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            pend_idx_reg   <= best_ext[stem_pkg::ENTRY_W-1:0];
            pend_again_reg <= again;
        end
        if ((cmd.apply && pend_valid_reg) || cmd.push_last)
        begin
            out_idx_reg   <= pend_idx_reg;
            out_again_reg <= pend_again_reg;
            out_last_reg  <= cmd.push_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign expired_entry = out_idx_reg;
    assign rearmed       = out_again_reg;
    assign last          = out_last_reg;

`ifndef SYNTHESIS
    // A held result always belongs to at least one reported expiry.
    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (res_cnt_reg != '0))
        else $error("pending result with zero result count");

    // The per-tick result count never exceeds its limit.
    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= stem_pkg::RES_CNT_W'(stem_pkg::MAX_RESULTS))
        else $error("too many results in one tick");

    // The chosen candidate is due at the current count.
    a_best_due: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_arr_reg <= count_reg))
        else $error("selected entry is not due");

    // A one-shot entry is freed once reported.
    a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && !again) |=> !armed_reg[$past(best_idx_reg)])
        else $error("one-shot entry still armed");
`endif

endmodule

// File: rtl/software_timer_expiry_manager.sv
// Software timer table with a free-running tick count. An arm transaction
// (mode 1) sets an entry's arrival to count plus delay and stores its reload
// period; a zero delay or an entry index outside the table is ignored.
// A tick transaction (mode 0) is acted on only while the running register
// is 1: it advances the count and then reports every due entry of the
// current group, earliest arrival first and lowest index on ties, at most
// 16 per tick, the final one flagged by last. Each report costs one scan
// of the arrival memory with its single read port, and a closing scan
// finds nothing more. When the sixteenth report is made the closing scan
// is skipped and the tick ends with a flush. Input is stalled while a tick
// is in work.
module software_timer_expiry_manager
#(
    parameter int TIMERS    = 16,
    parameter int TICK_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [stem_pkg::ENTRY_W-1:0] entry,
    input  logic [stem_pkg::FIELD_W-1:0] delay,
    input  logic [stem_pkg::FIELD_W-1:0] reload,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [stem_pkg::ENTRY_W-1:0] expired_entry,
    output logic                         rearmed,
    output logic                         last
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    stem_pkg::cmd_t cmd;
    stem_pkg::sts_t sts;

    // Sequencer.
    stem_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, count and result registers.
    stem_dp
    #(
        .TIMERS    (TIMERS),
        .TICK_BITS (TICK_BITS),
        .IW        (IW)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .entry         (entry),
        .delay         (delay),
        .reload        (reload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .expired_entry (expired_entry),
        .rearmed       (rearmed),
        .last          (last)
    );

endmodule
